/* src/fqd_pkg.sv */
// ----------------------------------------------------------------------------
// fqd_pkg
// Shared types and constants of the Q16.16 to decimal text formatter: the
// character codes, the divide-by-ten reciprocal and the controller/datapath
// command and status words.
// ----------------------------------------------------------------------------
package fqd_pkg;

   // field widths
   localparam int VALUE_W = 32;
   localparam int CHAR_W  = 8;
   localparam int IPART_W = 16;
   localparam int FRAC_W  = 16;
   localparam int DIGIT_W = 4;

   // digit counts
   localparam int INT_DIGITS  = 5;
   localparam int FRAC_DIGITS = 6;
   localparam int CNT_W       = $clog2(FRAC_DIGITS + 1);

   // x / 10 == (x * DIV10_RECIP) >> DIV10_SHIFT, exact for x below 43690
   localparam int DIV10_RECIP = 52429;
   localparam int DIV10_SHIFT = 19;
   localparam int PROD_W      = 32;
   localparam int QUOT_W      = PROD_W - DIV10_SHIFT;

   // ascii codes
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

   // which kind of character the datapath puts out
   typedef enum logic [1:0] {
      SEL_SIGN = 2'd0,
      SEL_INT  = 2'd1,
      SEL_DOT  = 2'd2,
      SEL_FRAC = 2'd3
   } sel_type;

   // controller to datapath
   typedef struct packed {
      logic    load;
      logic    conv;
      logic    emit;
      sel_type sel;
      logic    last;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic neg;
      logic conv_done;
      logic int_last;
      logic frac_last;
      logic out_ready;
   } dp_status_type;

endpackage

/* src/fqd_datapath.sv */
// ----------------------------------------------------------------------------
// fqd_datapath
// Magnitude and split of the input word, integer digit conversion by a
// reciprocal divide-by-ten, fraction digits by repeated times ten, and the
// output word register.
// ----------------------------------------------------------------------------
module fqd_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [fqd_pkg::VALUE_W-1:0]   req_value,
   input  fqd_pkg::dp_cmd_type           cmd,
   output fqd_pkg::dp_status_type        status,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [fqd_pkg::CHAR_W-1:0]    rsp_character,
   output logic                          rsp_last
);
   import fqd_pkg::*;

   logic                 neg_ff, neg_in;
   logic [IPART_W-1:0]   ipart_ff, ipart_in;
   logic [FRAC_W-1:0]    frac_ff, frac_in;
   logic [DIGIT_W-1:0]   digit_ff [INT_DIGITS];
   logic [DIGIT_W-1:0]   digit_in [INT_DIGITS];
   logic [CNT_W-1:0]     ndig_ff, ndig_in;
   logic [CNT_W-1:0]     fcnt_ff, fcnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [VALUE_W-1:0]   mag;
   logic [PROD_W-1:0]    prod;
   logic [IPART_W-1:0]   quot;
   logic [IPART_W-1:0]   quot10;
   logic [DIGIT_W-1:0]   rem;
   logic [FRAC_W+3:0]    frac10;
   logic [CNT_W-1:0]     ndig_m1;
   logic [DIGIT_W-1:0]   int_digit;
   logic                 out_ready;

   // magnitude in unsigned arithmetic, so the most negative value is 2^31
   assign mag = req_value[VALUE_W-1] ? (~req_value + VALUE_W'(1)) : req_value;

   // one divide-by-ten step on the integer part
   assign prod   = PROD_W'(ipart_ff) * PROD_W'(DIV10_RECIP);
   assign quot   = IPART_W'(prod[PROD_W-1:DIV10_SHIFT]);
   assign quot10 = (quot << 3) + (quot << 1);
   assign rem    = DIGIT_W'(ipart_ff - quot10);

   // times ten of the binary fraction, the integer overflow is the next digit
   assign frac10 = ((FRAC_W+4)'(frac_ff) << 3) + ((FRAC_W+4)'(frac_ff) << 1);

   // most significant pending integer digit
   assign ndig_m1   = ndig_ff - CNT_W'(1);
   assign int_digit = digit_ff[0];

   assign out_ready = !rsp_valid_ff || !rsp_stall;

   // status back to the controller
   always_comb begin
      status.neg       = neg_ff;
      status.conv_done = (quot == '0);
      status.int_last  = (ndig_ff == CNT_W'(1));
      status.frac_last = (fcnt_ff == CNT_W'(FRAC_DIGITS - 1));
      status.out_ready = out_ready;
   end

   // working registers
   always_comb begin
      neg_in   = neg_ff;
      ipart_in = ipart_ff;
      frac_in  = frac_ff;
      ndig_in  = ndig_ff;
      fcnt_in  = fcnt_ff;
      for (int i = 0; i < INT_DIGITS; i++) begin
         digit_in[i] = digit_ff[i];
      end
      if (cmd.load) begin
         neg_in   = req_value[VALUE_W-1];
         ipart_in = mag[VALUE_W-1:FRAC_W];
         frac_in  = mag[FRAC_W-1:0];
         ndig_in  = '0;
         fcnt_in  = '0;
      end else if (cmd.conv) begin
         // push the new digit into slot zero, older digits move up a slot
         ipart_in    = quot;
         ndig_in     = ndig_ff + CNT_W'(1);
         digit_in[0] = rem;
         for (int i = 1; i < INT_DIGITS; i++) begin
            digit_in[i] = digit_ff[i-1];
         end
      end else if (cmd.emit) begin
         if (cmd.sel == SEL_INT) begin
            // sent digit leaves, the next lower one moves to the front
            ndig_in = ndig_m1;
            for (int i = 0; i < INT_DIGITS - 1; i++) begin
               digit_in[i] = digit_ff[i+1];
            end
         end
         if (cmd.sel == SEL_FRAC) begin
            frac_in = frac10[FRAC_W-1:0];
            fcnt_in = fcnt_ff + CNT_W'(1);
         end
      end
   end

   // output word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = cmd.last;
         unique case (cmd.sel)
            SEL_SIGN: rsp_char_in = CHAR_MINUS;
            SEL_INT:  rsp_char_in = CHAR_ZERO + CHAR_W'(int_digit);
            SEL_DOT:  rsp_char_in = CHAR_DOT;
            SEL_FRAC: rsp_char_in = CHAR_ZERO + CHAR_W'(frac10[FRAC_W+3:FRAC_W]);
            default:  rsp_char_in = CHAR_DOT;
         endcase
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         ndig_ff      <= '0;
         fcnt_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         ndig_ff      <= ndig_in;
         fcnt_ff      <= fcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      ipart_ff    <= ipart_in;
      frac_ff     <= frac_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      for (int i = 0; i < INT_DIGITS; i++) begin
         digit_ff[i] <= digit_in[i];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // the integer part never needs more than five digits
   a_ndig_range: assert property (@(posedge clock) disable iff (reset)
      ndig_ff <= CNT_W'(INT_DIGITS))
      else $error("integer digit count out of range");

   // an integer digit is only sent while one is pending
   a_int_pending: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.sel == SEL_INT) |-> ndig_ff != '0)
      else $error("integer digit sent with none pending");

   // a sent fraction digit is a decimal digit
   a_frac_digit: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.sel == SEL_FRAC) |=> rsp_char_ff <= CHAR_ZERO + CHAR_W'(9))
      else $error("fraction digit above nine");
`endif

endmodule

/* src/fqd_control.sv */
// ----------------------------------------------------------------------------
// fqd_control
// Sequencer of the formatter: takes a word, runs the integer digit
// conversion, then steps through sign, integer digits, point and fraction
// digits, one output word per free output slot.
// ----------------------------------------------------------------------------
module fqd_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output fqd_pkg::dp_cmd_type     cmd,
   input  fqd_pkg::dp_status_type  status
);
   import fqd_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_CONV = 6'b000010,
      ST_SIGN = 6'b000100,
      ST_INT  = 6'b001000,
      ST_DOT  = 6'b010000,
      ST_FRAC = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd.load = 1'b0;
      cmd.conv = 1'b0;
      cmd.emit = 1'b0;
      cmd.sel  = SEL_DOT;
      cmd.last = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.conv = 1'b1;
            if (status.conv_done) begin
               state_in = status.neg ? ST_SIGN : ST_INT;
            end
         end
         ST_SIGN: begin
            cmd.sel = SEL_SIGN;
            if (status.out_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_INT;
            end
         end
         ST_INT: begin
            cmd.sel = SEL_INT;
            if (status.out_ready) begin
               cmd.emit = 1'b1;
               if (status.int_last) begin
                  state_in = ST_DOT;
               end
            end
         end
         ST_DOT: begin
            cmd.sel = SEL_DOT;
            if (status.out_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_FRAC;
            end
         end
         ST_FRAC: begin
            cmd.sel  = SEL_FRAC;
            cmd.last = status.frac_last;
            if (status.out_ready) begin
               cmd.emit = 1'b1;
               if (status.frac_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   // a word is only sent into a free output slot
   a_emit_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_ready)
      else $error("word sent into a full output slot");

   // a negative value always gets its sign right after conversion
   a_sign_next: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV && status.conv_done && status.neg) |=> state_ff == ST_SIGN)
      else $error("sign skipped on negative value");

   // the last flag only rides on the final fraction digit
   a_last_frac: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |-> (state_ff == ST_FRAC && status.frac_last))
      else $error("last flag outside the final fraction digit");

   // the point is followed by the fraction digits
   a_dot_frac: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DOT && status.out_ready) |=> state_ff == ST_FRAC)
      else $error("fraction does not follow the point");
`endif

endmodule

/* src/fixed_q16_to_decimal_text_top.sv */
// ----------------------------------------------------------------------------
// fixed_q16_to_decimal_text_top
// Q16.16 fixed-point to decimal ascii text formatter.
// ----------------------------------------------------------------------------
// One signed Q16.16 word in gives 8 to 13 ascii words out: an optional '-',
// the integer part of the magnitude without leading zeros, '.', and six
// truncated fraction digits; rsp_last marks the final word of each text.
// Words are handled one at a time. After a word is taken, the integer part
// is converted by one divide-by-ten step per cycle, one step per integer
// digit (1 to 5), then one character leaves per cycle while the output is
// not stalled. A new word is taken only once the final fraction digit has
// been sent and the sequencer is back in idle.
module fixed_q16_to_decimal_text_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fqd_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fqd_pkg::CHAR_W-1:0]    rsp_character,
   output logic                          rsp_last
);
   import fqd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   fqd_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // digit conversion and output register
   fqd_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .cmd           (cmd),
      .status        (status),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule
